// ===== hdl/chacha20_stream_cipher_unit_defines.svh =====
// Assertion macros shared by the ChaCha20 stream cipher RTL.
// Included by the controller and the datapath; uses clk_i and rst_ni of the includer.
`ifndef CHACHA20_STREAM_CIPHER_UNIT_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CHACHA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CHACHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/chacha_pkg.sv =====
// Shared types, constants and functions of the ChaCha20 stream cipher.
// Used by chacha_ctrl, chacha_dp and the top level; depends on nothing.
`default_nettype none

package chacha_pkg;

  localparam int unsigned DOUBLE_ROUNDS_DEF = 10;

  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_0_7   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_8_15  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_16_23 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_24_31 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_NONCE     = 3'd4;

  // "expand 32-byte k" as four little-endian words.
  localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

  typedef logic [15:0][31:0] block_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // latch the input item, apply a message restart
    logic load;    // load the working block from the initial block
    logic round;   // run one half quarter round
    logic diag;    // diagonal round taps instead of column taps
    logic half;    // second half of the quarter round, then rotate rows
    logic feed;    // feedforward add into the keystream block
    logic emit;    // write the result register, advance the word index
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_block;  // the offered item starts a new keystream block
    logic out_free;    // the result register can take a result this cycle
  } status_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic block_t build_init(input logic [63:0] k0, input logic [63:0] k1,
                                        input logic [63:0] k2, input logic [63:0] k3,
                                        input logic [63:0] ctr, input logic [63:0] nonce);
    block_t b;
    b[0]  = SIGMA_0;
    b[1]  = SIGMA_1;
    b[2]  = SIGMA_2;
    b[3]  = SIGMA_3;
    b[4]  = k0[31:0];
    b[5]  = k0[63:32];
    b[6]  = k1[31:0];
    b[7]  = k1[63:32];
    b[8]  = k2[31:0];
    b[9]  = k2[63:32];
    b[10] = k3[31:0];
    b[11] = k3[63:32];
    b[12] = ctr[31:0];
    b[13] = ctr[63:32];
    b[14] = nonce[31:0];
    b[15] = nonce[63:32];
    build_init = b;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/chacha20_stream_cipher_unit.sv =====
// Top level of the ChaCha20 stream cipher with 64-bit nonce and 64-bit block counter.
// Instantiates chacha_ctrl and chacha_dp; uses chacha_pkg.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o) carries one little-endian message
//   word per transfer with its valid byte count and first/last flags. The output
//   channel (out_valid_o / out_ready_i) returns exactly one result per input word:
//   the word XORed with the next keystream word, bytes beyond the count zeroed.
//   The user must write key and nonce via cfg_we_i / cfg_index_i / cfg_data_i only
//   while the block is idle; the block does not enforce it. Nothing is read back.
//   A word flagged first restarts the block counter and keystream position at zero.
//
// Sequencing:
//   A word that uses a stored keystream word goes through the emit state into the
//   output register; a word that starts a keystream block first passes the load,
//   round and feedforward states, on the single shared half quarter round unit.
//   The next word is taken while a result waits in the output register; if the
//   receiver stalls, the following result holds the sequencer and no word is taken.
//   Reset clears key, nonce, counter and position and empties the output register.
`default_nettype none

module chacha20_stream_cipher_unit #(
  parameter int unsigned DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [chacha_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [chacha_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [31:0]                        data_word_i,
  input  wire logic [2:0]                         valid_bytes_i,
  input  wire logic                               first_word_i,
  input  wire logic                               last_word_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [31:0]                             out_word_o,
  output logic [2:0]                              out_bytes_o,
  output logic                                    end_of_message_o
);

  chacha_pkg::cmd_t    cmd;
  chacha_pkg::status_t status;

  // The sequencer decides, at each input transfer, whether a new keystream
  // block must be built, steps the datapath through load, rounds and
  // feedforward if so, and then through the result write.
  chacha_ctrl #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds all payload state and the output register.
  chacha_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .data_word_i      (data_word_i),
    .valid_bytes_i    (valid_bytes_i),
    .first_word_i     (first_word_i),
    .last_word_i      (last_word_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_word_o       (out_word_o),
    .out_bytes_o      (out_bytes_o),
    .end_of_message_o (end_of_message_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule

`default_nettype wire

// ===== hdl/chacha_ctrl.sv =====
// Sequencer of the ChaCha20 stream cipher: item handshake, block generation steps.
// Depends on chacha_pkg and the assertion macro header.
`default_nettype none
`include "chacha20_stream_cipher_unit_defines.svh"

module chacha_ctrl #(
  parameter int unsigned DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire chacha_pkg::status_t status_i,
  output chacha_pkg::cmd_t         cmd_o
);

  // Each double round is 8 quarter rounds of 2 halves.
  localparam int unsigned NumSteps = DOUBLE_ROUNDS * 16;
  localparam int unsigned StepW    = $clog2(NumSteps);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FEED  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             step_last;
  logic             accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign step_last  = (step_q == StepW'(NumSteps - 1));

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = status_i.need_block ? ST_LOAD : ST_EMIT;
        end
      end
      ST_LOAD: begin
        step_d  = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        step_d = step_q + StepW'(1);
        if (step_last) begin
          state_d = ST_FEED;
        end
      end
      ST_FEED: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = accept;
    cmd_o.load   = (state_q == ST_LOAD);
    cmd_o.round  = (state_q == ST_ROUND);
    // Steps 0..7 of a double round are the column round, 8..15 the diagonal round.
    cmd_o.diag   = step_q[3];
    cmd_o.half   = step_q[0];
    cmd_o.feed   = (state_q == ST_FEED);
    cmd_o.emit   = (state_q == ST_EMIT) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  `CHACHA_ASSERT_NEXT(a_load_then_round, state_q == ST_LOAD, state_q == ST_ROUND && step_q == '0, "load not followed by first round step")
  `CHACHA_ASSERT_NEXT(a_rounds_then_feed, state_q == ST_ROUND && step_last, state_q == ST_FEED, "round sequence did not end in feedforward")
  `CHACHA_ASSERT_NEXT(a_emit_then_idle, cmd_o.emit, state_q == ST_IDLE, "emit did not return to idle")

endmodule

`default_nettype wire

// ===== hdl/chacha_dp.sv =====
// Datapath of the ChaCha20 stream cipher: configuration, working and keystream
// blocks, the shared half quarter round unit and the result register. Uses chacha_pkg.
`default_nettype none
`include "chacha20_stream_cipher_unit_defines.svh"

module chacha_dp (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [chacha_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  wire logic [chacha_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic [31:0]                            data_word_i,
  input  wire logic [2:0]                             valid_bytes_i,
  input  wire logic                                   first_word_i,
  input  wire logic                                   last_word_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic [31:0]                                 out_word_o,
  output logic [2:0]                                  out_bytes_o,
  output logic                                        end_of_message_o,
  input  wire chacha_pkg::cmd_t                       cmd_i,
  output chacha_pkg::status_t                         status_o
);

  logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_q;
  logic [63:0] ctr_q, ctr_d;
  logic [3:0]  idx_q, idx_d;

  logic [31:0] data_q;
  logic [2:0]  bytes_q;
  logic        last_q;

  chacha_pkg::block_t init_w, work_q, work_d, upd, rot;
  logic [31:0]        ks_q [16];

  logic [31:0] a_s, b_s, c_s, d_s, a_n, b_n, c_n, d_n, d_x, b_x;

  logic [31:0] ks_word, mask;
  logic [2:0]  cnt;

  logic        out_valid_q;
  logic [31:0] out_word_q;
  logic [2:0]  out_bytes_q;
  logic        eom_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q  <= '0;
      key1_q  <= '0;
      key2_q  <= '0;
      key3_q  <= '0;
      nonce_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        chacha_pkg::CFG_KEY_0_7:   key0_q  <= cfg_data_i;
        chacha_pkg::CFG_KEY_8_15:  key1_q  <= cfg_data_i;
        chacha_pkg::CFG_KEY_16_23: key2_q  <= cfg_data_i;
        chacha_pkg::CFG_KEY_24_31: key3_q  <= cfg_data_i;
        chacha_pkg::CFG_NONCE:     nonce_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign init_w = chacha_pkg::build_init(key0_q, key1_q, key2_q, key3_q, ctr_q, nonce_q);

  // Half quarter round on column 0 or on the main diagonal.
  always_comb begin
    a_s = work_q[0];
    b_s = cmd_i.diag ? work_q[5]  : work_q[4];
    c_s = cmd_i.diag ? work_q[10] : work_q[8];
    d_s = cmd_i.diag ? work_q[15] : work_q[12];
    a_n = a_s + b_s;
    d_x = d_s ^ a_n;
    d_n = cmd_i.half ? chacha_pkg::rotl(d_x, 8) : chacha_pkg::rotl(d_x, 16);
    c_n = c_s + d_n;
    b_x = b_s ^ c_n;
    b_n = cmd_i.half ? chacha_pkg::rotl(b_x, 7) : chacha_pkg::rotl(b_x, 12);
  end

  // After a whole quarter round every row turns left by one column, so the
  // next column or diagonal comes to the fixed taps.
  always_comb begin
    upd    = work_q;
    upd[0] = a_n;
    if (cmd_i.diag) begin
      upd[5]  = b_n;
      upd[10] = c_n;
      upd[15] = d_n;
    end else begin
      upd[4]  = b_n;
      upd[8]  = c_n;
      upd[12] = d_n;
    end
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        rot[r*4 + j] = upd[r*4 + ((j + 1) % 4)];
      end
    end
  end

  always_comb begin
    work_d = work_q;
    if (cmd_i.load) begin
      work_d = init_w;
    end else if (cmd_i.round) begin
      work_d = cmd_i.half ? rot : upd;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (cmd_i.feed) begin
      for (int i = 0; i < 16; i++) begin
        ks_q[i] <= work_q[i] + init_w[i];
      end
    end
    if (cmd_i.accept) begin
      data_q  <= data_word_i;
      bytes_q <= valid_bytes_i;
      last_q  <= last_word_i;
    end
  end

  // Result of the held item.
  assign ks_word = ks_q[idx_q];
  assign cnt     = (bytes_q > 3'd4) ? 3'd4 : bytes_q;

  always_comb begin
    unique case (cnt)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  always_comb begin
    ctr_d = ctr_q;
    idx_d = idx_q;
    if (cmd_i.accept && first_word_i) begin
      ctr_d = '0;
      idx_d = '0;
    end else if (cmd_i.emit) begin
      idx_d = idx_q + 4'd1;
      if (idx_q == 4'hf) begin
        ctr_d = ctr_q + 64'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ctr_q <= ctr_d;
      idx_q <= idx_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_word_q  <= (data_q ^ ks_word) & mask;
      out_bytes_q <= cnt;
      eom_q       <= last_q;
    end
  end

  assign status_o.need_block = first_word_i || (idx_q == 4'd0);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign out_word_o       = out_word_q;
  assign out_bytes_o      = out_bytes_q;
  assign end_of_message_o = eom_q;

  `CHACHA_ASSERT_NOW(a_emit_into_free_slot, cmd_i.emit, !out_valid_q || out_ready_i, "result written over an untaken result")
  `CHACHA_ASSERT_NEXT(a_counter_steps_at_wrap, cmd_i.emit && idx_q == 4'hf, ctr_q == $past(ctr_q) + 64'd1 && idx_q == 4'd0, "block counter did not advance at end of block")

endmodule

`default_nettype wire
